>>> design/rcm_pkg.sv
// Package: shared types, wiring tables and letter arithmetic for the rotor cipher unit
`default_nettype none
package rcm_pkg;
  localparam int unsigned Alpha = 26;

  typedef logic [4:0] letter_t;
  typedef logic [3:0] wheel_type_t;
  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_ENCIPHER = 2'd0;
  localparam cmd_t CMD_LOAD     = 2'd1;
  localparam cmd_t CMD_PLUG     = 2'd2;

  typedef enum logic [2:0] {
    REG_ROTOR_LEFT  = 3'd0,
    REG_ROTOR_MID   = 3'd1,
    REG_ROTOR_RIGHT = 3'd2,
    REG_RING_LEFT   = 3'd3,
    REG_RING_MID    = 3'd4,
    REG_RING_RIGHT  = 3'd5,
    REG_REFLECTOR   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    wheel_type_t rotor_left;
    wheel_type_t rotor_mid;
    wheel_type_t rotor_right;
    letter_t     ring_left;
    letter_t     ring_mid;
    letter_t     ring_right;
    logic        reflector_sel;
  } settings_t;

  typedef struct packed {
    logic    encipher;
    logic    plug;
    letter_t letter;
    letter_t partner;
    letter_t pos_left;
    letter_t pos_mid;
    letter_t pos_right;
  } job_t;

  localparam string WHEELS [8] = '{
    "EKMFLGDQVZNTOWYHXUSPAIBRCJ", "AJDKSIRUXBLHWTMCQGZNPYFVOE",
    "BDFHJLCPRTXVZNYEIWGAKMUSQO", "ESOVPZJAYQUIRHXLNFTGKDCMWB",
    "VZBRGITYUPSDNHLXAWMJQOFECK", "JPGVOUMFYQBENHZRDKASXLICTW",
    "NZJHGRCXMYSWBOUFAIVLPEKQDT", "FKQHTLXOCBJSPDZRAMEWNIUYGV"};
  localparam string REFLS [2] = '{
    "YRUHQSLDPXNGOKMIEBFZCWVJAT", "FVPJIAOYEDRZXWGCTKUQSBNMHL"};

  function automatic logic [2:0] type_idx(wheel_type_t t);
    logic [2:0] r;
    r = 3'd0;
    if (t >= 4'd1 && t <= 4'd8) r = 3'(t - 4'd1);
    return r;
  endfunction

  function automatic letter_t red(letter_t v);
    return (v >= letter_t'(Alpha)) ? letter_t'(v - letter_t'(Alpha)) : v;
  endfunction

  function automatic letter_t add26(letter_t a, letter_t b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 6'(Alpha)) s = s - 6'(Alpha);
    return s[4:0];
  endfunction

  function automatic letter_t sub26(letter_t a, letter_t b);
    logic [5:0] s;
    s = {1'b0, a} + 6'(Alpha) - {1'b0, b};
    if (s >= 6'(Alpha)) s = s - 6'(Alpha);
    return s[4:0];
  endfunction

  function automatic letter_t wire_fwd(logic [2:0] k, letter_t i);
    logic [7:0] ch;
    ch = WHEELS[k][i];
    return letter_t'(ch - 8'd65);
  endfunction

  function automatic letter_t wire_back(logic [2:0] k, letter_t x);
    letter_t r;
    r = '0;
    for (int i = 0; i < Alpha; i++) begin
      if (WHEELS[k][i] == 8'(x) + 8'd65) r = letter_t'(i);
    end
    return r;
  endfunction

  function automatic letter_t refl(logic s, letter_t i);
    logic [7:0] ch;
    ch = REFLS[s][i];
    return letter_t'(ch - 8'd65);
  endfunction

  function automatic logic at_notch(wheel_type_t t, letter_t p);
    logic r;
    unique case (type_idx(t))
      3'd0: r = (p == 5'd16);
      3'd1: r = (p == 5'd4);
      3'd2: r = (p == 5'd21);
      3'd3: r = (p == 5'd9);
      3'd4: r = (p == 5'd25);
      default: r = (p == 5'd25) || (p == 5'd12);
    endcase
    return r;
  endfunction

  function automatic letter_t wheel_f(wheel_type_t t, letter_t sh, letter_t x);
    return sub26(wire_fwd(type_idx(t), add26(x, sh)), sh);
  endfunction

  function automatic letter_t wheel_b(wheel_type_t t, letter_t sh, letter_t x);
    return sub26(wire_back(type_idx(t), add26(x, sh)), sh);
  endfunction
endpackage
`default_nettype wire

>>> design/rcm_if.sv
// Interfaces: item, result and configuration channels
`default_nettype none
interface rcm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [4:0] letter;
  logic [4:0] partner;
  logic [4:0] start_left;
  logic [4:0] start_mid;
  logic [4:0] start_right;
  modport source (output valid, cmd, letter, partner, start_left, start_mid, start_right,
                  input ready);
  modport sink (input valid, cmd, letter, partner, start_left, start_mid, start_right,
                output ready);
endinterface

interface rcm_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] cipher_letter;
  logic [4:0] now_left;
  logic [4:0] now_mid;
  logic [4:0] now_right;
  modport source (output valid, cipher_letter, now_left, now_mid, now_right, input ready);
  modport sink (input valid, cipher_letter, now_left, now_mid, now_right, output ready);
endinterface

interface rcm_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [4:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/rcm_front.sv
// Front end: accepts beats, steps and loads wheels, flags valid plug pairs
`default_nettype none
module rcm_front (
  input  wire logic            clk,
  input  wire logic            rst,
  rcm_in_if.sink               in_ch,
  input  wire rcm_pkg::settings_t cfg,
  output rcm_pkg::job_t        job,
  output logic                 job_valid,
  input  wire logic            job_ready
);
  import rcm_pkg::*;

  letter_t pos_l, pos_m, pos_r;
  letter_t pos_l_next, pos_m_next, pos_r_next;
  logic    take, mid_n, right_n;

  assign in_ch.ready = job_ready;
  assign job_valid   = in_ch.valid;
  assign take        = in_ch.valid && job_ready;

  always_comb begin
    mid_n   = at_notch(cfg.rotor_mid, pos_m);
    right_n = at_notch(cfg.rotor_right, pos_r);
    pos_l_next = pos_l;
    pos_m_next = pos_m;
    pos_r_next = pos_r;
    case (in_ch.cmd)
      CMD_ENCIPHER: begin
        if (mid_n) begin
          pos_l_next = add26(pos_l, 5'd1);
          pos_m_next = add26(pos_m, 5'd1);
        end else if (right_n) begin
          pos_m_next = add26(pos_m, 5'd1);
        end
        pos_r_next = add26(pos_r, 5'd1);
      end
      CMD_LOAD: begin
        pos_l_next = red(in_ch.start_left);
        pos_m_next = red(in_ch.start_mid);
        pos_r_next = red(in_ch.start_right);
      end
      default: ;
    endcase
    job.encipher  = (in_ch.cmd == CMD_ENCIPHER);
    job.plug      = (in_ch.cmd == CMD_PLUG) && (in_ch.letter < 5'd26) &&
                    (in_ch.partner < 5'd26);
    job.letter    = in_ch.letter;
    job.partner   = in_ch.partner;
    job.pos_left  = pos_l_next;
    job.pos_mid   = pos_m_next;
    job.pos_right = pos_r_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_l <= '0;
      pos_m <= '0;
      pos_r <= '0;
    end else if (take) begin
      pos_l <= pos_l_next;
      pos_m <= pos_m_next;
      pos_r <= pos_r_next;
    end
  end
endmodule
`default_nettype wire

>>> design/rcm_queue.sv
// Two-entry queue between front and back end
`default_nettype none
module rcm_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire rcm_pkg::job_t  in_job,
  input  wire logic           in_valid,
  output logic                in_ready,
  output rcm_pkg::job_t       out_job,
  output logic                out_valid,
  input  wire logic           out_ready
);
  import rcm_pkg::*;

  job_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_job   = mem[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_job;
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

>>> design/rcm_back.sv
// Back end: plugboard, wheel path in two stages, result register
`default_nettype none
module rcm_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rcm_pkg::settings_t cfg,
  input  wire rcm_pkg::job_t      job,
  input  wire logic               job_valid,
  output logic                    job_ready,
  rcm_out_if.source               out_ch
);
  import rcm_pkg::*;

  letter_t plug [26];
  letter_t sh_l, sh_m, sh_r, c0, c1, c2, c3, c4;
  letter_t oa, ob;
  logic    s1_valid, s1_ready, adv, load;
  job_t    s1;
  letter_t s1_c;
  letter_t d1, d2, d3;
  logic    out_free;

  always_comb begin
    sh_l = sub26(job.pos_left, red(cfg.ring_left));
    sh_m = sub26(job.pos_mid, red(cfg.ring_mid));
    sh_r = sub26(job.pos_right, red(cfg.ring_right));
    c0 = plug[red(job.letter)];
    c1 = wheel_f(cfg.rotor_right, sh_r, c0);
    c2 = wheel_f(cfg.rotor_mid, sh_m, c1);
    c3 = wheel_f(cfg.rotor_left, sh_l, c2);
    c4 = refl(cfg.reflector_sel, c3);
    oa = plug[job.plug ? job.letter : 5'd0];
    ob = plug[job.plug ? job.partner : 5'd0];
  end

  always_comb begin
    d1 = wheel_b(cfg.rotor_left, sub26(s1.pos_left, red(cfg.ring_left)), s1_c);
    d2 = wheel_b(cfg.rotor_mid, sub26(s1.pos_mid, red(cfg.ring_mid)), d1);
    d3 = wheel_b(cfg.rotor_right, sub26(s1.pos_right, red(cfg.ring_right)), d2);
  end

  assign out_free  = !out_ch.valid || out_ch.ready;
  assign adv       = s1_valid && out_free;
  assign s1_ready  = !s1_valid || out_free;
  assign job_ready = s1_ready;
  assign load      = job_valid && s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Alpha; i++) plug[i] <= letter_t'(i);
    end else if (load && job.plug) begin
      for (int i = 0; i < Alpha; i++) begin
        if (letter_t'(i) == job.letter) plug[i] <= job.partner;
        else if (letter_t'(i) == job.partner) plug[i] <= job.letter;
        else if (letter_t'(i) == oa || letter_t'(i) == ob) plug[i] <= letter_t'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1   <= job;
      s1_c <= c4;
    end
    if (adv) begin
      out_ch.cipher_letter <= s1.encipher ? plug[d3] : 5'd0;
      out_ch.now_left      <= s1.pos_left;
      out_ch.now_mid       <= s1.pos_mid;
      out_ch.now_right     <= s1.pos_right;
    end
    if (rst) begin
      s1_valid     <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= job_valid;
      if (out_free) out_ch.valid <= s1_valid;
    end
  end
endmodule
`default_nettype wire

>>> design/rotor_cipher_machine_unit.sv
// Top level: rotor cipher unit with configuration registers
// An accepted beat goes through the queue, the wheel stage and the output register.
// Throughput: one beat per cycle when out_ch is ready; wheel path in two register stages.
// Result order follows input order; a two-entry queue separates front and back end.
// Synchronous reset: wheels at A, plugs identity, wheel types I II III, rings A, reflector B.
`default_nettype none
module rotor_cipher_machine_unit (
  input  wire logic clk,
  input  wire logic rst,
  rcm_in_if.sink    in_ch,
  rcm_out_if.source out_ch,
  rcm_cfg_if.sink   cfg_ch
);
  import rcm_pkg::*;

  settings_t cfg;
  job_t      fj, qj;
  logic      fv, fr, qv, qr;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotor_left    <= 4'd1;
      cfg.rotor_mid     <= 4'd2;
      cfg.rotor_right   <= 4'd3;
      cfg.ring_left     <= '0;
      cfg.ring_mid      <= '0;
      cfg.ring_right    <= '0;
      cfg.reflector_sel <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_ROTOR_LEFT:  cfg.rotor_left    <= cfg_ch.data[3:0];
        REG_ROTOR_MID:   cfg.rotor_mid     <= cfg_ch.data[3:0];
        REG_ROTOR_RIGHT: cfg.rotor_right   <= cfg_ch.data[3:0];
        REG_RING_LEFT:   cfg.ring_left     <= cfg_ch.data;
        REG_RING_MID:    cfg.ring_mid      <= cfg_ch.data;
        REG_RING_RIGHT:  cfg.ring_right    <= cfg_ch.data;
        REG_REFLECTOR:   cfg.reflector_sel <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  rcm_front u_front (.clk, .rst, .in_ch, .cfg, .job(fj), .job_valid(fv), .job_ready(fr));
  rcm_queue u_queue (.clk, .rst, .in_job(fj), .in_valid(fv), .in_ready(fr),
                     .out_job(qj), .out_valid(qv), .out_ready(qr));
  rcm_back u_back (.clk, .rst, .cfg, .job(qj), .job_valid(qv), .job_ready(qr), .out_ch);
endmodule
`default_nettype wire

>>> tb/rotor_cipher_machine_unit_tb.sv
// Testbench: drives commands into the rotor cipher unit and checks every result beat
`timescale 1ns / 100ps
module rotor_cipher_machine_unit_tb;
  import rcm_pkg::*;

  typedef struct {
    logic [1:0] cmd;
    logic [4:0] letter;
    logic [4:0] partner;
    logic [4:0] sl, sm, sr;
  } key_t;

  typedef struct {
    logic [4:0] cl, nl, nm, nr;
  } lamp_t;

  localparam string WIRING [8] = '{
    "EKMFLGDQVZNTOWYHXUSPAIBRCJ", "AJDKSIRUXBLHWTMCQGZNPYFVOE",
    "BDFHJLCPRTXVZNYEIWGAKMUSQO", "ESOVPZJAYQUIRHXLNFTGKDCMWB",
    "VZBRGITYUPSDNHLXAWMJQOFECK", "JPGVOUMFYQBENHZRDKASXLICTW",
    "NZJHGRCXMYSWBOUFAIVLPEKQDT", "FKQHTLXOCBJSPDZRAMEWNIUYGV"};
  localparam string REFLECT [2] = '{
    "YRUHQSLDPXNGOKMIEBFZCWVJAT", "FVPJIAOYEDRZXWGCTKUQSBNMHL"};

  logic clk, rst;
  rcm_in_if  in_ch ();
  rcm_out_if out_ch ();
  rcm_cfg_if cfg_ch ();

  rotor_cipher_machine_unit u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // model state
  logic [3:0] m_type [3];
  logic [4:0] m_ring [3];
  logic       m_refl;
  int         m_pos [3];
  int         m_plug [26];

  key_t  key_q [$];
  lamp_t lamp_q [$];
  int    errors = 0;
  int    send_idle = 0, recv_stall = 0;
  int    hold_off = 0;

  function automatic int wheel_no(logic [3:0] t);
    return (t >= 1 && t <= 8) ? int'(t) - 1 : 0;
  endfunction

  function automatic bit notch_hit(logic [3:0] t, int p);
    case (wheel_no(t))
      0: return p == 16;
      1: return p == 4;
      2: return p == 21;
      3: return p == 9;
      4: return p == 25;
      default: return p == 25 || p == 12;
    endcase
  endfunction

  function automatic int pass_fwd(int s, int x);
    int k, sh;
    k = wheel_no(m_type[s]);
    sh = (m_pos[s] + 26 - int'(m_ring[s]) % 26) % 26;
    return (int'(WIRING[k][(x + sh) % 26]) - 65 + 26 - sh) % 26;
  endfunction

  function automatic int pass_back(int s, int x);
    int k, sh, tg, y;
    k = wheel_no(m_type[s]);
    sh = (m_pos[s] + 26 - int'(m_ring[s]) % 26) % 26;
    tg = (x + sh) % 26;
    y = 0;
    for (int i = 0; i < 26; i++) if (int'(WIRING[k][i]) - 65 == tg) y = i;
    return (y + 26 - sh) % 26;
  endfunction

  function automatic lamp_t press_key(key_t k);
    lamp_t r;
    int c, a, b, oa, ob;
    c = 0;
    if (k.cmd == CMD_ENCIPHER) begin
      if (notch_hit(m_type[1], m_pos[1])) begin
        m_pos[0] = (m_pos[0] + 1) % 26;
        m_pos[1] = (m_pos[1] + 1) % 26;
      end else if (notch_hit(m_type[2], m_pos[2])) m_pos[1] = (m_pos[1] + 1) % 26;
      m_pos[2] = (m_pos[2] + 1) % 26;
      c = m_plug[int'(k.letter) % 26];
      c = pass_fwd(2, c);
      c = pass_fwd(1, c);
      c = pass_fwd(0, c);
      c = int'(REFLECT[m_refl][c]) - 65;
      c = pass_back(0, c);
      c = pass_back(1, c);
      c = pass_back(2, c);
      c = m_plug[c];
    end else if (k.cmd == CMD_LOAD) begin
      m_pos[0] = int'(k.sl) % 26;
      m_pos[1] = int'(k.sm) % 26;
      m_pos[2] = int'(k.sr) % 26;
    end else if (k.cmd == CMD_PLUG) begin
      a = k.letter; b = k.partner;
      if (a < 26 && b < 26) begin
        oa = m_plug[a]; ob = m_plug[b];
        m_plug[oa] = oa; m_plug[ob] = ob;
        m_plug[a] = b; m_plug[b] = a;
      end
    end
    r.cl = 5'(c); r.nl = 5'(m_pos[0]); r.nm = 5'(m_pos[1]); r.nr = 5'(m_pos[2]);
    return r;
  endfunction

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        lamp_q.push_back(press_key(key_q.pop_front()));
      end
      if ((!in_ch.valid || in_ch.ready) || !in_ch.valid) begin
        if ((in_ch.valid && in_ch.ready) || !in_ch.valid) begin
          if ((in_ch.valid && in_ch.ready ? key_q.size() > 0 : key_q.size() > 0) &&
              ($urandom_range(99) >= send_idle)) begin
            in_ch.valid <= 1'b1;
            in_ch.cmd <= key_q[0].cmd;
            in_ch.letter <= key_q[0].letter;
            in_ch.partner <= key_q[0].partner;
            in_ch.start_left <= key_q[0].sl;
            in_ch.start_mid <= key_q[0].sm;
            in_ch.start_right <= key_q[0].sr;
          end else begin
            in_ch.valid <= 1'b0;
          end
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    lamp_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (lamp_q.size() == 0) begin
          $display("%0t: unexpected beat, actual %0d %0d %0d %0d", $realtime,
                   out_ch.cipher_letter, out_ch.now_left, out_ch.now_mid, out_ch.now_right);
          errors++;
        end else begin
          e = lamp_q.pop_front();
          if (out_ch.cipher_letter !== e.cl || out_ch.now_left !== e.nl ||
              out_ch.now_mid !== e.nm || out_ch.now_right !== e.nr) begin
            $display("%0t: expected %0d %0d %0d %0d, actual %0d %0d %0d %0d", $realtime,
                     e.cl, e.nl, e.nm, e.nr, out_ch.cipher_letter, out_ch.now_left,
                     out_ch.now_mid, out_ch.now_right);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  task automatic drain();
    int n;
    n = 0;
    while ((key_q.size() > 0 || lamp_q.size() > 0 || in_ch.valid) && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= 5'(val);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ROTOR_LEFT:  m_type[0] = 4'(val);
      REG_ROTOR_MID:   m_type[1] = 4'(val);
      REG_ROTOR_RIGHT: m_type[2] = 4'(val);
      REG_RING_LEFT:   m_ring[0] = 5'(val);
      REG_RING_MID:    m_ring[1] = 5'(val);
      REG_RING_RIGHT:  m_ring[2] = 5'(val);
      default:         m_refl = 1'(val);
    endcase
  endtask

  task automatic add_key(int c, int l, int p, int a, int b, int d);
    key_t k;
    k.cmd = 2'(c); k.letter = 5'(l); k.partner = 5'(p);
    k.sl = 5'(a); k.sm = 5'(b); k.sr = 5'(d);
    key_q.push_back(k);
  endtask

  task automatic add_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 75) add_key(CMD_ENCIPHER, $urandom_range(31), $urandom_range(31),
                          $urandom_range(31), $urandom_range(31), $urandom_range(31));
      else if (r < 83) add_key(CMD_LOAD, $urandom_range(31), $urandom_range(31),
                               $urandom_range(31), $urandom_range(31), $urandom_range(31));
      else if (r < 95) add_key(CMD_PLUG, $urandom_range(r < 93 ? 25 : 31),
                               $urandom_range(25), $urandom_range(31), 0, $urandom_range(31));
      else add_key(2'd3, $urandom_range(31), $urandom_range(31),
                   $urandom_range(31), $urandom_range(31), $urandom_range(31));
    end
  endtask

  task automatic random_settings();
    write_reg(REG_ROTOR_LEFT, $urandom_range(15));
    write_reg(REG_ROTOR_MID, $urandom_range(15));
    write_reg(REG_ROTOR_RIGHT, $urandom_range(15));
    write_reg(REG_RING_LEFT, $urandom_range(31));
    write_reg(REG_RING_MID, $urandom_range(31));
    write_reg(REG_RING_RIGHT, $urandom_range(31));
    write_reg(REG_REFLECTOR, $urandom_range(1));
  endtask

  initial begin
    m_type[0] = 1; m_type[1] = 2; m_type[2] = 3;
    m_ring[0] = 0; m_ring[1] = 0; m_ring[2] = 0;
    m_refl = 0;
    for (int i = 0; i < 3; i++) m_pos[i] = 0;
    for (int i = 0; i < 26; i++) m_plug[i] = i;
    in_ch.valid = 0; in_ch.cmd = 0; in_ch.letter = 0; in_ch.partner = 0;
    in_ch.start_left = 0; in_ch.start_mid = 0; in_ch.start_right = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.index = REG_ROTOR_LEFT; cfg_ch.data = 0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, double step, plugs, out of range
    add_key(CMD_ENCIPHER, 0, 0, 0, 0, 0);
    add_key(CMD_ENCIPHER, 25, 0, 0, 0, 0);
    add_key(CMD_LOAD, 0, 0, 0, 3, 20);
    add_key(CMD_ENCIPHER, 31, 0, 0, 0, 0);
    add_key(CMD_ENCIPHER, 26, 0, 0, 0, 0);
    add_key(CMD_ENCIPHER, 7, 0, 0, 0, 0);
    add_key(CMD_LOAD, 0, 0, 31, 26, 25);
    add_key(CMD_PLUG, 0, 25, 0, 0, 0);
    add_key(CMD_PLUG, 0, 5, 0, 0, 0);
    add_key(CMD_PLUG, 5, 5, 0, 0, 0);
    add_key(CMD_PLUG, 31, 3, 0, 0, 0);
    add_key(CMD_PLUG, 3, 31, 0, 0, 0);
    add_key(CMD_ENCIPHER, 0, 0, 0, 0, 0);
    add_key(CMD_ENCIPHER, 25, 0, 0, 0, 0);
    add_key(2'd3, 31, 31, 31, 31, 31);
    add_key(CMD_ENCIPHER, 3, 0, 0, 0, 0);
    drain();
    write_reg(REG_ROTOR_LEFT, 8); write_reg(REG_ROTOR_MID, 6);
    write_reg(REG_ROTOR_RIGHT, 0); write_reg(REG_RING_LEFT, 25);
    write_reg(REG_RING_MID, 31); write_reg(REG_RING_RIGHT, 0);
    write_reg(REG_REFLECTOR, 1);
    add_key(CMD_LOAD, 0, 0, 0, 11, 15);
    for (int i = 0; i < 6; i++) add_key(CMD_ENCIPHER, i, 0, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 87; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 87; end
        default: begin send_idle = 38; recv_stall = 38; end
      endcase
      if (ph == 4) begin
        write_reg(REG_ROTOR_LEFT, 15); write_reg(REG_ROTOR_MID, 5);
        write_reg(REG_ROTOR_RIGHT, 9); write_reg(REG_RING_LEFT, 0);
        write_reg(REG_RING_MID, 0); write_reg(REG_RING_RIGHT, 26);
        write_reg(REG_REFLECTOR, 0);
      end else if (ph > 0) random_settings();
      if (ph == 0) hold_off = 300;
      add_random(290);
      drain();
    end

    if (errors == 0 && lamp_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

>>> filelist.f
design/rcm_pkg.sv
design/rcm_if.sv
design/rcm_front.sv
design/rcm_queue.sv
design/rcm_back.sv
design/rotor_cipher_machine_unit.sv
tb/rotor_cipher_machine_unit_tb.sv
